FILE: design/rsam_pkg.sv
// ----------------------------------------------------------------------------
// rsam_pkg: shared types and constants for the rotated array minimum block
// Holds the default sizes, the controller state type, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsam_pkg;

    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int DEF_VALUE_WIDTH  = 16;
    localparam int IO_WIDTH         = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHECK,
        ST_RD_MID,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_first;
        logic rd_last;
        logic check;
        logic rd_mid;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic converged;
    } t_dp_stat;

endpackage

FILE: design/rotated_sorted_array_minimum_core.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_minimum_core: minimum of a rotated ascending array
//
//   Channel  Direction  Handshake               Payload
//   in       input      i_in_valid/o_in_stall    i_value, i_last
//   out      output     o_out_valid/i_out_stall  o_minimum, o_overflowed
//
// Elements load at one transfer per cycle, unless stalled, into a
// single-port-read store. After the last element the input stalls while the
// first and last elements are read and checked and the search steps (at most
// ceil(log2 n)) run; each step costs one store read and one compare, bounded
// by the store's registered read port. A result still waiting lengthens the
// stall. Reset is synchronous and active low; it clears the fill count and
// drop flag. The output register lets loading continue while a result waits.
// ----------------------------------------------------------------------------
module rotated_sorted_array_minimum_core
    import rsam_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [IO_WIDTH-1:0] i_value,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IO_WIDTH-1:0] o_minimum,
    output logic                o_overflowed
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rsam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    rsam_dp #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_minimum   (o_minimum),
        .o_overflowed(o_overflowed)
    );

endmodule

FILE: design/rsam_ram.sv
// ----------------------------------------------------------------------------
// rsam_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rsam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rsam_dp.sv
// ----------------------------------------------------------------------------
// rsam_dp: datapath of the rotated array minimum block
// Element store, fill count, drop flag, search bounds and the output register.
// ----------------------------------------------------------------------------
module rsam_dp
    import rsam_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [IO_WIDTH-1:0] i_value,
    input  logic                i_last,
    output logic [IO_WIDTH-1:0] o_minimum,
    output logic                o_overflowed
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_ELEMENTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

    logic [CW-1:0]          r_count;
    logic                   r_ovf;
    logic                   r_res_ovf;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_mid;
    logic [VALUE_WIDTH-1:0] r_lo_val;
    logic [VALUE_WIDTH-1:0] r_hi_val;
    logic [IO_WIDTH-1:0]    r_min;
    logic                   r_out_ovf;

    logic                   w_room;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [IO_WIDTH-1:0]    w_min;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_mid;
    logic                   w_gt;
    logic [AW-1:0]          n_lo;
    logic [AW-1:0]          n_hi;

    generate
        if (VALUE_WIDTH <= IO_WIDTH) begin : g_narrow
            assign w_value = i_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign w_value = {{(VALUE_WIDTH-IO_WIDTH){i_value[IO_WIDTH-1]}}, i_value};
        end
        if (VALUE_WIDTH >= IO_WIDTH) begin : g_out_trunc
            assign w_min = r_hi_val[IO_WIDTH-1:0];
        end else begin : g_out_ext
            assign w_min = {{(IO_WIDTH-VALUE_WIDTH){1'b0}}, r_hi_val};
        end
    endgenerate

    assign w_room = (r_count < MAX_CNT);
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        priority if (i_cmd.rd_first) begin
            w_raddr = '0;
        end else if (i_cmd.rd_last) begin
            w_raddr = r_hi;
        end else if (i_cmd.rd_mid) begin
            w_raddr = w_mid;
        end else begin
            w_raddr = '0;
        end
    end

    rsam_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept && w_room),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // A search step: the middle element above the right bound means the
    // minimum lies to the right of mid.
    assign w_gt = $signed(w_rdata) > $signed(r_hi_val);
    assign n_lo = w_gt ? r_mid + AW'(1) : r_lo;
    assign n_hi = w_gt ? r_hi : r_mid;

    assign o_stat.early     = ($signed(r_lo_val) < $signed(w_rdata)) || (r_lo == r_hi);
    assign o_stat.converged = (n_lo == n_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (w_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_lo      <= '0;
            r_hi      <= w_room ? r_count[AW-1:0] : LAST_ADDR;
            r_res_ovf <= r_ovf || !w_room;
        end
        if (i_cmd.rd_last) begin
            r_lo_val <= w_rdata;
        end
        // The right bound's value doubles as the result once the search ends.
        if (i_cmd.check) begin
            r_hi_val <= o_stat.early ? r_lo_val : w_rdata;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= w_mid;
        end
        if (i_cmd.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (!w_gt) begin
                r_hi_val <= w_rdata;
            end
        end
        if (i_cmd.load_out) begin
            r_min     <= w_min;
            r_out_ovf <= r_res_ovf;
        end
    end

    assign o_minimum    = r_min;
    assign o_overflowed = r_out_ovf;

endmodule

FILE: design/rsam_ctrl.sv
// ----------------------------------------------------------------------------
// rsam_ctrl: controller of the rotated array minimum block
// Sequences loading, the search over the store, and the output register.
// ----------------------------------------------------------------------------
module rsam_ctrl
    import rsam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_last,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_last) begin
                    n_state = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: n_state = ST_RD_LAST;
            ST_RD_LAST:  n_state = ST_CHECK;
            ST_CHECK:    n_state = i_stat.early ? ST_DONE : ST_RD_MID;
            ST_RD_MID:   n_state = ST_STEP;
            ST_STEP:     n_state = i_stat.converged ? ST_DONE : ST_RD_MID;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default:     n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_RD_FIRST: o_cmd.rd_first = 1'b1;
            ST_RD_LAST:  o_cmd.rd_last  = 1'b1;
            ST_CHECK:    o_cmd.check    = 1'b1;
            ST_RD_MID:   o_cmd.rd_mid   = 1'b1;
            ST_STEP:     o_cmd.step     = 1'b1;
            ST_DONE:     o_cmd.load_out = w_out_free;
            default:     o_cmd          = '0;
        endcase
    end

    always_comb begin
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/rsam_checker.sv
// ----------------------------------------------------------------------------
// rsam_checker: port-level checks for the rotated array minimum block
// Watches both channels and the search stall that follows a last element.
// ----------------------------------------------------------------------------
module rsam_checker
    import rsam_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_last,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [IO_WIDTH-1:0] o_minimum,
    input logic                o_overflowed
);

    logic w_last_xfer;

    assign w_last_xfer = i_in_valid && !o_in_stall && i_last;

    // A result waiting under stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_minimum) && $stable(o_overflowed))
        else $error("output payload changed while stalled");

    // The input stays stalled while the first and last elements are read and checked.
    a_search_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_xfer |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken during the search");

    // A new result only appears at the end of a search.
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a search");

endmodule

bind rotated_sorted_array_minimum_core rsam_checker u_rsam_checker (.*);
